@@ rtl/cau_pkg.sv @@
// Shared types, constants and a helper function of the complex arithmetic unit.
package cau_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS     = 16;
   localparam int PROD_BITS     = 2 * WORD_BITS;
   localparam int SUM_BITS      = PROD_BITS + 1;
   localparam int DIV_BITS      = 3 * WORD_BITS;
   localparam int ROOT_REM_BITS = WORD_BITS + 2;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_EQ   = 3'd4,
      OP_NE   = 3'd5,
      OP_MOD  = 3'd6,
      OP_NONE = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type                   opcode;
      logic signed [WORD_BITS-1:0]  a_re;
      logic signed [WORD_BITS-1:0]  a_im;
      logic signed [WORD_BITS-1:0]  b_re;
      logic signed [WORD_BITS-1:0]  b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0]  res_re;
      logic signed [WORD_BITS-1:0]  res_im;
      logic                         compare_flag;
      status_type                   status;
   } rsp_type;

   // Products of the first multiply stage.
   typedef struct packed {
      opcode_type                   opcode;
      logic signed [PROD_BITS-1:0]  p_rr;
      logic signed [PROD_BITS-1:0]  p_ii;
      logic signed [PROD_BITS-1:0]  p_ir;
      logic signed [PROD_BITS-1:0]  p_ri;
      logic signed [PROD_BITS-1:0]  p_sq0;
      logic signed [PROD_BITS-1:0]  p_sq1;
      rsp_type                      early;
   } prod_type;

   // Sums of products.
   typedef struct packed {
      opcode_type                   opcode;
      logic signed [SUM_BITS-1:0]   num_re;
      logic signed [SUM_BITS-1:0]   num_im;
      logic [PROD_BITS-1:0]         sq;
      rsp_type                      early;
   } sum_type;

   // State carried through the divide and square root steps.
   typedef struct packed {
      opcode_type                   opcode;
      rsp_type                      early;
      logic [PROD_BITS-1:0]         den;
      logic                         neg_re;
      logic                         neg_im;
      logic                         over_re;
      logic                         over_im;
      logic [DIV_BITS-1:0]          rem_re;
      logic [DIV_BITS-1:0]          rem_im;
      logic [WORD_BITS-1:0]         q_re;
      logic [WORD_BITS-1:0]         q_im;
      logic [PROD_BITS-1:0]         root_src;
      logic [ROOT_REM_BITS-1:0]     root_rem;
      logic [WORD_BITS-1:0]         root;
   } lane_type;

   // Clamps a sign and magnitude to the word range; the top bit flags a clamp.
   function automatic logic [WORD_BITS:0] saturate(input logic neg,
                                                    input logic [SUM_BITS-1:0] mag);
      logic [SUM_BITS-1:0]  lim;
      logic [WORD_BITS-1:0] m;
      logic                 over;
      lim = SUM_BITS'(1) << (WORD_BITS - 1);
      if (!neg) begin
         lim = lim - SUM_BITS'(1);
      end
      over = (mag > lim);
      m = over ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
      saturate = {over, (neg ? (-m) : m)};
   endfunction

endpackage

@@ rtl/cau_mult.sv @@
// Operand multiply stage and sum-of-products stage, plus add, subtract and compare.
module cau_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cau_pkg::req_type   in_req,
   output logic               out_valid,
   output cau_pkg::sum_type   out_sum
);

   localparam int W = cau_pkg::WORD_BITS;

   logic                 prod_valid_ff;
   cau_pkg::prod_type    prod_ff, prod_in;
   logic                 sum_valid_ff;
   cau_pkg::sum_type     sum_ff, sum_in;

   logic signed [W:0]    add_re, add_im;
   logic [W:0]           mag_re, mag_im;
   logic [W:0]           sat_re, sat_im;
   logic signed [W-1:0]  sq_x, sq_y;
   logic                 equal;

   always_comb begin
      prod_in.opcode = in_req.opcode;
      sq_x = (in_req.opcode == cau_pkg::OP_MOD) ? in_req.a_re : in_req.b_re;
      sq_y = (in_req.opcode == cau_pkg::OP_MOD) ? in_req.a_im : in_req.b_im;
      prod_in.p_rr  = in_req.a_re * in_req.b_re;
      prod_in.p_ii  = in_req.a_im * in_req.b_im;
      prod_in.p_ir  = in_req.a_im * in_req.b_re;
      prod_in.p_ri  = in_req.a_re * in_req.b_im;
      prod_in.p_sq0 = sq_x * sq_x;
      prod_in.p_sq1 = sq_y * sq_y;

      if (in_req.opcode == cau_pkg::OP_SUB) begin
         add_re = (W+1)'(in_req.a_re) - (W+1)'(in_req.b_re);
         add_im = (W+1)'(in_req.a_im) - (W+1)'(in_req.b_im);
      end else begin
         add_re = (W+1)'(in_req.a_re) + (W+1)'(in_req.b_re);
         add_im = (W+1)'(in_req.a_im) + (W+1)'(in_req.b_im);
      end
      mag_re = add_re[W] ? (-add_re) : add_re;
      mag_im = add_im[W] ? (-add_im) : add_im;
      sat_re = cau_pkg::saturate(add_re[W], cau_pkg::SUM_BITS'(mag_re));
      sat_im = cau_pkg::saturate(add_im[W], cau_pkg::SUM_BITS'(mag_im));
      equal  = (in_req.a_re == in_req.b_re) && (in_req.a_im == in_req.b_im);

      prod_in.early = '0;
      unique case (in_req.opcode)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            prod_in.early.res_re = sat_re[W-1:0];
            prod_in.early.res_im = sat_im[W-1:0];
            prod_in.early.status = (sat_re[W] || sat_im[W]) ? cau_pkg::ST_SAT
                                                             : cau_pkg::ST_OK;
         end
         cau_pkg::OP_EQ: begin
            prod_in.early.compare_flag = equal;
         end
         cau_pkg::OP_NE: begin
            prod_in.early.compare_flag = !equal;
         end
         default: begin
            prod_in.early = '0;
         end
      endcase
   end

   always_comb begin
      sum_in.opcode = prod_ff.opcode;
      sum_in.early  = prod_ff.early;
      if (prod_ff.opcode == cau_pkg::OP_MUL) begin
         sum_in.num_re = cau_pkg::SUM_BITS'(prod_ff.p_rr) - cau_pkg::SUM_BITS'(prod_ff.p_ii);
         sum_in.num_im = cau_pkg::SUM_BITS'(prod_ff.p_ir) + cau_pkg::SUM_BITS'(prod_ff.p_ri);
      end else begin
         sum_in.num_re = cau_pkg::SUM_BITS'(prod_ff.p_rr) + cau_pkg::SUM_BITS'(prod_ff.p_ii);
         sum_in.num_im = cau_pkg::SUM_BITS'(prod_ff.p_ir) - cau_pkg::SUM_BITS'(prod_ff.p_ri);
      end
      // Both squares are non-negative, so their sum fits the product width.
      sum_in.sq = prod_ff.p_sq0 + prod_ff.p_sq1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign out_valid = sum_valid_ff;
   assign out_sum   = sum_ff;

endmodule

@@ rtl/cau_setup.sv @@
// Rounds products and prepares dividend, divisor and radicand for the step chain.
module cau_setup (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cau_pkg::sum_type   in_sum,
   output logic               out_valid,
   output cau_pkg::lane_type  out_lane
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int F  = cau_pkg::FRAC_BITS;
   localparam int SB = cau_pkg::SUM_BITS;

   logic                 valid_ff;
   cau_pkg::lane_type    lane_ff, lane_in;

   logic [SB-1:0]        mag_re, mag_im, rnd_re, rnd_im;
   logic [W:0]           sat_re, sat_im;
   logic [cau_pkg::DIV_BITS-1:0] dvd_re, dvd_im, limit;

   always_comb begin
      mag_re = in_sum.num_re[SB-1] ? (-in_sum.num_re) : in_sum.num_re;
      mag_im = in_sum.num_im[SB-1] ? (-in_sum.num_im) : in_sum.num_im;
      rnd_re = (mag_re + (SB'(1) << (F - 1))) >> F;
      rnd_im = (mag_im + (SB'(1) << (F - 1))) >> F;
      sat_re = cau_pkg::saturate(in_sum.num_re[SB-1], rnd_re);
      sat_im = cau_pkg::saturate(in_sum.num_im[SB-1], rnd_im);

      dvd_re = cau_pkg::DIV_BITS'(mag_re) << F;
      dvd_im = cau_pkg::DIV_BITS'(mag_im) << F;
      // A quotient of 2^W or more saturates whatever its low bits are.
      limit  = cau_pkg::DIV_BITS'(in_sum.sq) << W;

      lane_in.opcode = in_sum.opcode;
      lane_in.early  = in_sum.early;
      if (in_sum.opcode == cau_pkg::OP_MUL) begin
         lane_in.early.res_re = sat_re[W-1:0];
         lane_in.early.res_im = sat_im[W-1:0];
         lane_in.early.status = (sat_re[W] || sat_im[W]) ? cau_pkg::ST_SAT
                                                         : cau_pkg::ST_OK;
      end
      lane_in.den      = in_sum.sq;
      lane_in.neg_re   = in_sum.num_re[SB-1];
      lane_in.neg_im   = in_sum.num_im[SB-1];
      lane_in.over_re  = (dvd_re >= limit);
      lane_in.over_im  = (dvd_im >= limit);
      lane_in.rem_re   = dvd_re;
      lane_in.rem_im   = dvd_im;
      lane_in.q_re     = '0;
      lane_in.q_im     = '0;
      lane_in.root_src = in_sum.sq;
      lane_in.root_rem = '0;
      lane_in.root     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

@@ rtl/cau_step.sv @@
// One quotient bit of both restoring dividers and one root bit of the square root.
module cau_step #(
   parameter int STEP = cau_pkg::WORD_BITS - 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cau_pkg::lane_type  in_lane,
   output logic               out_valid,
   output cau_pkg::lane_type  out_lane
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int DB = cau_pkg::DIV_BITS;
   localparam int RB = cau_pkg::ROOT_REM_BITS;

   logic                 valid_ff;
   cau_pkg::lane_type    lane_ff, lane_in;

   logic [DB-1:0]        trial;
   logic [RB+1:0]        cur, root_trial;
   logic                 bit_re, bit_im, bit_root;

   always_comb begin
      lane_in = in_lane;
      trial   = DB'(in_lane.den) << STEP;

      bit_re = (in_lane.rem_re >= trial);
      bit_im = (in_lane.rem_im >= trial);
      if (bit_re) begin
         lane_in.rem_re = in_lane.rem_re - trial;
      end
      if (bit_im) begin
         lane_in.rem_im = in_lane.rem_im - trial;
      end
      lane_in.q_re = {in_lane.q_re[W-2:0], bit_re};
      lane_in.q_im = {in_lane.q_im[W-2:0], bit_im};

      // Bring down the next two radicand bits and try 4 * root + 1.
      cur        = {in_lane.root_rem, in_lane.root_src[cau_pkg::PROD_BITS-1 -: 2]};
      root_trial = {2'b00, in_lane.root, 2'b01};
      bit_root   = (cur >= root_trial);
      lane_in.root_rem = bit_root ? RB'(cur - root_trial) : RB'(cur);
      lane_in.root     = {in_lane.root[W-2:0], bit_root};
      lane_in.root_src = in_lane.root_src << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

@@ rtl/cau_final.sv @@
// Rounds quotients and the root, saturates, and registers the result.
module cau_final (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cau_pkg::lane_type  in_lane,
   output logic               rsp_strobe,
   output cau_pkg::rsp_type   rsp_data
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int PB = cau_pkg::PROD_BITS;
   localparam int SB = cau_pkg::SUM_BITS;

   logic                 rsp_strobe_ff;
   cau_pkg::rsp_type     rsp_ff, rsp_in;

   logic [W:0]           qr_re, qr_im, root_r;
   logic [W:0]           sat_re, sat_im, sat_root;
   logic [SB-1:0]        mag_re, mag_im;

   always_comb begin
      qr_re  = {1'b0, in_lane.q_re} +
               (W+1)'({in_lane.rem_re[PB-1:0], 1'b0} >= SB'(in_lane.den));
      qr_im  = {1'b0, in_lane.q_im} +
               (W+1)'({in_lane.rem_im[PB-1:0], 1'b0} >= SB'(in_lane.den));
      mag_re = in_lane.over_re ? '1 : SB'(qr_re);
      mag_im = in_lane.over_im ? '1 : SB'(qr_im);
      sat_re = cau_pkg::saturate(in_lane.neg_re, mag_re);
      sat_im = cau_pkg::saturate(in_lane.neg_im, mag_im);

      root_r   = {1'b0, in_lane.root} +
                 (W+1)'(in_lane.root_rem > cau_pkg::ROOT_REM_BITS'(in_lane.root));
      sat_root = cau_pkg::saturate(1'b0, SB'(root_r));

      rsp_in = in_lane.early;
      if (in_lane.opcode == cau_pkg::OP_DIV) begin
         rsp_in = '0;
         if (in_lane.den == '0) begin
            rsp_in.status = cau_pkg::ST_DIV_ZERO;
         end else begin
            rsp_in.res_re = sat_re[W-1:0];
            rsp_in.res_im = sat_im[W-1:0];
            rsp_in.status = (sat_re[W] || sat_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
         end
      end else if (in_lane.opcode == cau_pkg::OP_MOD) begin
         rsp_in        = '0;
         rsp_in.res_re = sat_root[W-1:0];
         rsp_in.status = sat_root[W] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // A divide by zero magnitude leaves both parts at zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_ff.status == cau_pkg::ST_DIV_ZERO) |->
         (rsp_ff.res_re == '0) && (rsp_ff.res_im == '0) && !rsp_ff.compare_flag)
      else $error("divide by zero result not cleared");

   // A saturated result has at least one part at an end of the word range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_ff.status == cau_pkg::ST_SAT) |->
         (rsp_ff.res_re == {1'b0, {(W-1){1'b1}}}) || (rsp_ff.res_re == {1'b1, {(W-1){1'b0}}}) ||
         (rsp_ff.res_im == {1'b0, {(W-1){1'b1}}}) || (rsp_ff.res_im == {1'b1, {(W-1){1'b0}}}))
      else $error("saturation flagged without a clamped part");

   // The modulus is never negative and has no imaginary part.
   assert property (@(posedge clock) disable iff (reset)
      in_valid && (in_lane.opcode == cau_pkg::OP_MOD) |=>
         !rsp_ff.res_re[W-1] && (rsp_ff.res_im == '0) && !rsp_ff.compare_flag)
      else $error("modulus result malformed");

   // Compares give zero parts and an ok status.
   assert property (@(posedge clock) disable iff (reset)
      in_valid && ((in_lane.opcode == cau_pkg::OP_EQ) || (in_lane.opcode == cau_pkg::OP_NE)) |=>
         (rsp_ff.res_re == '0) && (rsp_ff.res_im == '0) && (rsp_ff.status == cau_pkg::ST_OK))
      else $error("compare result malformed");

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// Top level of the pipelined complex arithmetic unit on signed fixed-point operands.
//
//   channel   ports                       handshake
//   request   start, busy, req_data       taken when start is high and busy is low
//   response  rsp_strobe, rsp_data        one cycle per result, cannot be held off
//
// A new transaction can enter in every cycle; busy is always low.
// From start to rsp_strobe a transaction passes the input register, multiply, sum,
// setup, one divide and root bit per stage for WORD_BITS stages, then rounding and
// the output register.
// Results come out in the order the transactions went in.
// Reset is synchronous and clears only the valid bits of the pipeline.
module complex_arithmetic_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cau_pkg::req_type   req_data,
   output logic               rsp_strobe,
   output cau_pkg::rsp_type   rsp_data
);

   localparam int W = cau_pkg::WORD_BITS;

   logic                 req_valid_ff;
   cau_pkg::req_type     req_ff;
   logic                 sum_valid;
   cau_pkg::sum_type     sum_data;
   logic                 step_valid [0:W];
   cau_pkg::lane_type    step_lane  [0:W];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   cau_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_req    (req_ff),
      .out_valid (sum_valid),
      .out_sum   (sum_data)
   );

   cau_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_sum    (sum_data),
      .out_valid (step_valid[0]),
      .out_lane  (step_lane[0])
   );

   for (genvar k = 0; k < W; k++) begin : g_step
      cau_step #(
         .STEP (W - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[k]),
         .in_lane   (step_lane[k]),
         .out_valid (step_valid[k+1]),
         .out_lane  (step_lane[k+1])
      );
   end

   cau_final u_final (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (step_valid[W]),
      .in_lane    (step_lane[W]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/complex_arithmetic_unit_checker.sv @@
// Scoreboard for the complex arithmetic unit: predicts each result and compares it.
`timescale 1ns / 100ps
module complex_arithmetic_unit_checker
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  req_type  req_data,
   input  logic     rsp_strobe,
   input  rsp_type  rsp_data,
   output int       errors,
   output int       pending
);

   rsp_type awaited_results[$];

   // Clamps a sign and magnitude to the word range; the top bit marks a clamp.
   function automatic logic [WORD_BITS:0] clamp_word(input logic neg, input logic [159:0] mag);
      logic [159:0] lim;
      logic [WORD_BITS-1:0] m;
      logic over;
      lim = 160'd1 << (WORD_BITS - 1);
      if (!neg) begin
         lim = lim - 160'd1;
      end
      over = (mag > lim);
      m = over ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
      return {over, (neg ? (-m) : m)};
   endfunction

   // Magnitude of |num| * 2^FRAC_BITS / den, rounded half away from zero.
   function automatic logic [159:0] scaled_quotient(input logic [159:0] num,
                                                    input logic [159:0] den);
      logic [159:0] q;
      logic [159:0] r;
      q = (num << FRAC_BITS) / den;
      r = (num << FRAC_BITS) - q * den;
      if ((r << 1) >= den) begin
         q = q + 160'd1;
      end
      return q;
   endfunction

   function automatic logic [79:0] rounded_root(input logic [79:0] s);
      logic [79:0] r;
      logic [79:0] t;
      r = '0;
      for (int i = 33; i >= 0; i--) begin
         t = r | (80'd1 << i);
         if (t * t <= s) begin
            r = t;
         end
      end
      if (s - r * r > r) begin
         r = r + 80'd1;
      end
      return r;
   endfunction

   function automatic rsp_type predict_result(input req_type rq);
      rsp_type res;
      logic signed [33:0] sum_re;
      logic signed [33:0] sum_im;
      logic signed [65:0] part_re;
      logic signed [65:0] part_im;
      logic [159:0] mag;
      logic [159:0] den;
      logic [79:0] sq;
      logic [WORD_BITS:0] c_re;
      logic [WORD_BITS:0] c_im;
      logic eq;
      res = '0;
      c_re = '0;
      c_im = '0;
      case (rq.opcode)
         OP_ADD, OP_SUB: begin
            if (rq.opcode == OP_ADD) begin
               sum_re = 34'(rq.a_re) + 34'(rq.b_re);
               sum_im = 34'(rq.a_im) + 34'(rq.b_im);
            end else begin
               sum_re = 34'(rq.a_re) - 34'(rq.b_re);
               sum_im = 34'(rq.a_im) - 34'(rq.b_im);
            end
            c_re = clamp_word(sum_re < 0, 160'(sum_re < 0 ? -sum_re : sum_re));
            c_im = clamp_word(sum_im < 0, 160'(sum_im < 0 ? -sum_im : sum_im));
         end
         OP_MUL: begin
            part_re = 66'(rq.a_re) * 66'(rq.b_re) - 66'(rq.a_im) * 66'(rq.b_im);
            part_im = 66'(rq.a_im) * 66'(rq.b_re) + 66'(rq.a_re) * 66'(rq.b_im);
            mag = 160'(part_re < 0 ? -part_re : part_re);
            c_re = clamp_word(part_re < 0, (mag + (160'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            mag = 160'(part_im < 0 ? -part_im : part_im);
            c_im = clamp_word(part_im < 0, (mag + (160'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
         end
         OP_DIV: begin
            if (rq.b_re == 0 && rq.b_im == 0) begin
               res.status = ST_DIV_ZERO;
            end else begin
               part_re = 66'(rq.b_re) * 66'(rq.b_re) + 66'(rq.b_im) * 66'(rq.b_im);
               den = 160'(part_re);
               part_re = 66'(rq.a_re) * 66'(rq.b_re) + 66'(rq.a_im) * 66'(rq.b_im);
               part_im = 66'(rq.b_re) * 66'(rq.a_im) - 66'(rq.a_re) * 66'(rq.b_im);
               c_re = clamp_word(part_re < 0,
                  scaled_quotient(160'(part_re < 0 ? -part_re : part_re), den));
               c_im = clamp_word(part_im < 0,
                  scaled_quotient(160'(part_im < 0 ? -part_im : part_im), den));
            end
         end
         OP_EQ, OP_NE: begin
            eq = (rq.a_re == rq.b_re) && (rq.a_im == rq.b_im);
            res.compare_flag = (rq.opcode == OP_EQ) ? eq : !eq;
         end
         OP_MOD: begin
            part_re = 66'(rq.a_re) * 66'(rq.a_re) + 66'(rq.a_im) * 66'(rq.a_im);
            sq = rounded_root(80'(part_re));
            c_re = clamp_word(1'b0, 160'(sq));
         end
         default: begin
         end
      endcase
      res.res_re = c_re[WORD_BITS-1:0];
      res.res_im = c_im[WORD_BITS-1:0];
      if (c_re[WORD_BITS] || c_im[WORD_BITS]) begin
         res.status = ST_SAT;
      end
      return res;
   endfunction

   assign pending = awaited_results.size();

   initial begin
      errors = 0;
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = awaited_results.pop_front();
            if (rsp_data.res_re !== exp_rsp.res_re) begin
               $display("%0t: res_re expected %h actual %h", $time, exp_rsp.res_re,
                        rsp_data.res_re);
               errors++;
            end
            if (rsp_data.res_im !== exp_rsp.res_im) begin
               $display("%0t: res_im expected %h actual %h", $time, exp_rsp.res_im,
                        rsp_data.res_im);
               errors++;
            end
            if (rsp_data.compare_flag !== exp_rsp.compare_flag) begin
               $display("%0t: compare_flag expected %b actual %b", $time,
                        exp_rsp.compare_flag, rsp_data.compare_flag);
               errors++;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                        rsp_data.status);
               errors++;
            end
         end
      end
      if (!reset && start && !busy) begin
         awaited_results.push_back(predict_result(req_data));
      end
   end

   final begin
      if (awaited_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_results.size());
      end
   end

endmodule

@@ tb/complex_arithmetic_unit_tb.sv @@
// Top of the complex arithmetic unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int PIPE_CYCLES = WORD_BITS + 5;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   req_type  req_data;
   logic     rsp_strobe;
   rsp_type  rsp_data;
   int       errors;
   int       pending;
   int       idle_pct;

   complex_arithmetic_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   complex_arithmetic_unit_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = ~clock;
   end

   // Corner values are favored so that saturation and rounding edges come up often.
   function automatic logic [WORD_BITS-1:0] pick_operand();
      case ($urandom_range(9))
         0: return '0;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return 32'h00010000;
         4: return 32'hffff0000;
         5, 6: return 32'($signed($urandom_range(32'h1ffffe)) - 32'sh0fffff);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(input opcode_type op, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{opcode: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      logic [31:0] ar;
      logic [31:0] ai;
      logic [31:0] br;
      logic [31:0] bi;
      opcode_type op;
      for (int n = 0; n < count; n++) begin
         op = opcode_type'($urandom_range(20) == 0 ? 7 : $urandom_range(6));
         ar = pick_operand();
         ai = pick_operand();
         br = pick_operand();
         bi = pick_operand();
         if ((op == OP_EQ || op == OP_NE) && $urandom_range(2) == 0) begin
            br = ar;
            bi = ($urandom_range(1) == 0) ? ai : ai ^ (32'd1 << $urandom_range(31));
         end
         if (op == OP_DIV && $urandom_range(9) == 0) begin
            br = '0;
            bi = '0;
         end
         send_op(op, ar, ai, br, bi);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_op(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
      send_op(OP_ADD, 32'h00018000, 32'hfffe0000, 32'h00008000, 32'h00010000);
      send_op(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
      send_op(OP_SUB, 32'h00030000, 32'h0, 32'h00010000, 32'h80000000);
      send_op(OP_MUL, 32'h00020000, 32'h00030000, 32'hffff0000, 32'h00008000);
      send_op(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_op(OP_MUL, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h0);
      send_op(OP_MUL, 32'h00000001, 32'h0, 32'h00008000, 32'h0);
      send_op(OP_MUL, 32'hffffffff, 32'h0, 32'h00008000, 32'h0);
      send_op(OP_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0);
      send_op(OP_DIV, 32'h00030000, 32'h00010000, 32'h00010000, 32'hffff0000);
      send_op(OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 32'h0);
      send_op(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_op(OP_DIV, 32'h00000001, 32'h0, 32'h00030000, 32'h0);
      send_op(OP_EQ, 32'h12345678, 32'h80000000, 32'h12345678, 32'h80000000);
      send_op(OP_EQ, 32'h12345678, 32'h80000000, 32'h12345678, 32'h80000001);
      send_op(OP_NE, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h0);
      send_op(OP_NE, 32'h7fffffff, 32'h0, 32'hffffffff, 32'h0);
      send_op(OP_MOD, 32'h80000000, 32'h80000000, 32'hffffffff, 32'hffffffff);
      send_op(OP_MOD, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0);
      send_op(OP_MOD, 32'h00000001, 32'h00000001, 32'h0, 32'h0);
      send_op(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

      send_random(420);
      idle_pct = 80;
      send_random(400);
      // Let the pipeline drain completely before the next transaction.
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      idle_pct = 20;
      send_random(410);
      idle_pct = 0;
      send_random(420);

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_CYCLES + 10) @(negedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cau_pkg.sv
rtl/cau_mult.sv
rtl/cau_setup.sv
rtl/cau_step.sv
rtl/cau_final.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_checker.sv
tb/complex_arithmetic_unit_tb.sv
